FILE: sv/fbp_pkg.sv
// Shared types, RGB565 layout constants and the per-length reciprocal table.
package fbp_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OFF_W   = 6;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned FIELD_W = 8;
  localparam int unsigned PROD_W  = 16;  // field times 255
  localparam int unsigned RECIP_W = 25;  // ceil(2^24 / (2^len - 1))
  localparam int unsigned SHIFT   = 24;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_RED_OFF  = 3'd1,
    REG_RED_LEN  = 3'd2,
    REG_GRN_OFF  = 3'd3,
    REG_GRN_LEN  = 3'd4,
    REG_BLU_OFF  = 3'd5,
    REG_BLU_LEN  = 3'd6
  } reg_idx_t;

  // Fixed RGB565 layout
  localparam logic [OFF_W-1:0] R565_OFF = 6'd11;
  localparam logic [LEN_W-1:0] R565_LEN = 4'd5;
  localparam logic [OFF_W-1:0] G565_OFF = 6'd5;
  localparam logic [LEN_W-1:0] G565_LEN = 4'd6;
  localparam logic [OFF_W-1:0] B565_OFF = 6'd0;
  localparam logic [LEN_W-1:0] B565_LEN = 4'd5;

  // Per-stage advance strobes of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } fbp_adv_t;

  // Reciprocal of (2^len - 1) scaled by 2^24, rounded up. A length of zero
  // marks a channel that reads as zero, so its factor is zero.
  function automatic logic [RECIP_W-1:0] fbp_recip(input logic [LEN_W-1:0] len);
    logic [RECIP_W-1:0] m;
    case (len)
      4'd1:    m = 25'd16777216;
      4'd2:    m = 25'd5592406;
      4'd3:    m = 25'd2396746;
      4'd4:    m = 25'd1118482;
      4'd5:    m = 25'd541201;
      4'd6:    m = 25'd266306;
      4'd7:    m = 25'd132105;
      4'd8:    m = 25'd65794;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/fbp_extract.sv
// Stage one: check one channel's field window and cut the field out of the word.
module fbp_extract import fbp_pkg::*; (
  input  logic               clk,
  input  fbp_adv_t           adv,
  input  logic [WORD_W-1:0]  word,
  input  logic [OFF_W-1:0]   off,
  input  logic [LEN_W-1:0]   len,
  output logic [FIELD_W-1:0] field_o,
  output logic [LEN_W-1:0]   len_o
);

  logic [FIELD_W-1:0] field_r, field_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ok;
  logic [OFF_W:0]     span;
  logic [WORD_W-1:0]  shifted;
  logic [FIELD_W:0]   mask;

  always_comb begin
    span    = {1'b0, off} + {3'b000, len};
    ok      = (len != '0) && (len <= 4'd8) && !off[OFF_W-1] && (span <= 7'd32);
    shifted = word >> off[OFF_W-2:0];
    mask    = (9'h001 << len) - 9'h001;
    // drop the field entirely when the window is not usable
    field_nxt = ok ? (shifted[FIELD_W-1:0] & mask[FIELD_W-1:0]) : '0;
    len_nxt   = ok ? len : '0;
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      field_r <= field_nxt;
      len_r   <= len_nxt;
    end
  end

  assign field_o = field_r;
  assign len_o   = len_r;

endmodule

FILE: sv/fbp_scale.sv
// Stages two and three: multiply the field by 255, then divide by 2^len-1
// through a reciprocal multiply.
module fbp_scale import fbp_pkg::*; (
  input  logic               clk,
  input  fbp_adv_t           adv,
  input  logic [FIELD_W-1:0] field_i,
  input  logic [LEN_W-1:0]   len_i,
  output logic [FIELD_W-1:0] byte_o
);

  logic [PROD_W-1:0]         x_r, x_nxt;
  logic [LEN_W-1:0]          len_r;
  logic [FIELD_W-1:0]        q_r, q_nxt;
  logic [PROD_W+RECIP_W-1:0] prod;

  assign x_nxt = {field_i, 8'h00} - {8'h00, field_i};

  always_comb begin
    prod  = x_r * fbp_recip(len_r);
    q_nxt = prod[SHIFT+FIELD_W-1:SHIFT];
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      x_r   <= x_nxt;
      len_r <= len_i;
    end
    if (adv.s3) begin
      q_r <= q_nxt;
    end
  end

  assign byte_o = q_r;

endmodule

FILE: sv/framebuffer_pixel_to_rgb888.sv
// Top level: framebuffer pixel word to RGB888 expansion, three-stage pipeline.
//
//  channel  direction  payload                                   handshake
//  in_      slave      tdata[31:0] pixel_word                    tvalid/tready
//  out_     master     tdata[23:0] red, green, blue (low first)  tvalid/tready
//  cfg_     write      wdata[5:0] to register cfg_index          cfg_we
//
// One pixel per cycle is accepted while out_tready does not back the pipeline up;
// each pixel passes extract, multiply by 255 and reciprocal multiply to output valid.
// Each stage holds its transaction while the next one is full and blocked, so a
// stall on out_tready backs up stage by stage and bubbles are squeezed out.
// Synchronous active-low reset clears the valid bits and loads the register
// defaults (RGB565 mode, 8-8-8 fields at 16/8/0).
module framebuffer_pixel_to_rgb888 import fbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] red_byte, [15:8] green_byte, [23:16] blue_byte
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);

  logic             mode_r;
  logic [OFF_W-1:0] red_off_r, grn_off_r, blu_off_r;
  logic [LEN_W-1:0] red_len_r, grn_len_r, blu_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      red_off_r <= 6'd16;
      red_len_r <= 4'd8;
      grn_off_r <= 6'd8;
      grn_len_r <= 4'd8;
      blu_off_r <= 6'd0;
      blu_len_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode_r    <= cfg_wdata[0];
        REG_RED_OFF: red_off_r <= cfg_wdata;
        REG_RED_LEN: red_len_r <= cfg_wdata[LEN_W-1:0];
        REG_GRN_OFF: grn_off_r <= cfg_wdata;
        REG_GRN_LEN: grn_len_r <= cfg_wdata[LEN_W-1:0];
        REG_BLU_OFF: blu_off_r <= cfg_wdata;
        REG_BLU_LEN: blu_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Pipeline control
  logic     v1_r, v2_r, v3_r;
  logic     rdy1, rdy2, rdy3;
  fbp_adv_t adv;

  assign rdy3 = !v3_r || out_tready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign adv  = '{s1: rdy1, s2: rdy2, s3: rdy3};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  assign in_tready  = rdy1;
  assign out_tvalid = v3_r;

  // Field windows: fixed layout in RGB565 mode, registers otherwise
  logic [OFF_W-1:0]   r_off, g_off, b_off;
  logic [LEN_W-1:0]   r_len, g_len, b_len;
  logic [FIELD_W-1:0] r_fld, g_fld, b_fld;
  logic [LEN_W-1:0]   r_l1, g_l1, b_l1;
  logic [FIELD_W-1:0] r_byte, g_byte, b_byte;

  always_comb begin
    r_off = mode_r ? red_off_r : R565_OFF;
    r_len = mode_r ? red_len_r : R565_LEN;
    g_off = mode_r ? grn_off_r : G565_OFF;
    g_len = mode_r ? grn_len_r : G565_LEN;
    b_off = mode_r ? blu_off_r : B565_OFF;
    b_len = mode_r ? blu_len_r : B565_LEN;
  end

  fbp_extract u_ext_r (.clk(clk), .adv(adv), .word(in_tdata), .off(r_off), .len(r_len),
                       .field_o(r_fld), .len_o(r_l1));
  fbp_extract u_ext_g (.clk(clk), .adv(adv), .word(in_tdata), .off(g_off), .len(g_len),
                       .field_o(g_fld), .len_o(g_l1));
  fbp_extract u_ext_b (.clk(clk), .adv(adv), .word(in_tdata), .off(b_off), .len(b_len),
                       .field_o(b_fld), .len_o(b_l1));

  fbp_scale u_scl_r (.clk(clk), .adv(adv), .field_i(r_fld), .len_i(r_l1), .byte_o(r_byte));
  fbp_scale u_scl_g (.clk(clk), .adv(adv), .field_i(g_fld), .len_i(g_l1), .byte_o(g_byte));
  fbp_scale u_scl_b (.clk(clk), .adv(adv), .field_i(b_fld), .len_i(b_l1), .byte_o(b_byte));

  assign out_tdata = {b_byte, g_byte, r_byte};

  // A result appears only out of a filled second stage
  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v2_r))
    else $error("output valid without a transaction in stage two");

  // Input back-pressure only when every stage is full
  a_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with a free stage");

  // A blocked stage one keeps its transaction
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> v1_r)
    else $error("stage one lost a stalled transaction");

endmodule

FILE: sim/framebuffer_pixel_to_rgb888_tb.sv
// Self-checking testbench for the framebuffer pixel to RGB888 expander.
module framebuffer_pixel_to_rgb888_tb import fbp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 3;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_WAIT     = 16;

  // An index outside the register list
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef enum logic {
    MODE_RGB565 = 1'b0,
    MODE_PACKED = 1'b1
  } pixel_mode_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [5:0]  cfg_wdata  = '0;

  // Register copies used by the predictor
  pixel_mode_t mode_q       = MODE_RGB565;
  logic [5:0]  red_off_q    = 6'd16;
  logic [3:0]  red_len_q    = 4'd8;
  logic [5:0]  green_off_q  = 6'd8;
  logic [3:0]  green_len_q  = 4'd8;
  logic [5:0]  blue_off_q   = 6'd0;
  logic [3:0]  blue_len_q   = 4'd8;

  rgb_t pending_rgb[$];
  int   error_count   = 0;
  int   rgb565_pixels = 0;
  int   packed_pixels = 0;
  int   results_seen  = 0;
  int   settings_used = 1;
  int   idle_cycles   = 0;
  bit   sender_burst  = 1'b0;
  bit   sink_burst    = 1'b0;

  framebuffer_pixel_to_rgb888 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] scale_channel(logic [31:0] word, logic [5:0] off,
                                               logic [3:0] len);
    int unsigned top;
    int unsigned v;
    if (len == 0 || len > 8 || off >= 32 || int'(off) + int'(len) > 32) return 8'd0;
    top = (32'd1 << len) - 1;
    v   = (word >> off) & top;
    return 8'((v * 255) / top);
  endfunction

  function automatic rgb_t expand_pixel(logic [31:0] word);
    rgb_t px;
    if (mode_q == MODE_RGB565) begin
      px.red   = 8'((int'(word[15:11]) * 255) / 31);
      px.green = 8'((int'(word[10:5]) * 255) / 63);
      px.blue  = 8'((int'(word[4:0]) * 255) / 31);
    end else begin
      px.red   = scale_channel(word, red_off_q, red_len_q);
      px.green = scale_channel(word, green_off_q, green_len_q);
      px.blue  = scale_channel(word, blue_off_q, blue_len_q);
    end
    return px;
  endfunction

  function automatic int draw_wait(bit burst);
    if (burst || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, MAX_WAIT);
  endfunction

  function automatic logic [31:0] random_pixel();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'd1 << k;
      3:       return ~(32'd1 << k);
      default: return $urandom;
    endcase
  endfunction

  // Present one pixel and hold it until the DUT takes it
  task automatic send_pixel(input logic [31:0] word);
    int gap;
    gap = draw_wait(sender_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    pending_rgb.push_back(expand_pixel(word));
    if (mode_q == MODE_RGB565) rgb565_pixels++;
    else packed_pixels++;
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  // Wait for every outstanding result, then let the pipeline empty
  task automatic drain();
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [5:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_MODE:    mode_q      = pixel_mode_t'(data[0]);
      REG_RED_OFF: red_off_q   = data;
      REG_RED_LEN: red_len_q   = data[3:0];
      REG_GRN_OFF: green_off_q = data;
      REG_GRN_LEN: green_len_q = data[3:0];
      REG_BLU_OFF: blue_off_q  = data;
      REG_BLU_LEN: blue_len_q  = data[3:0];
      default: ;
    endcase
  endtask

  // Spare high bits go out random so the DUT must ignore them
  task automatic apply_config(input pixel_mode_t mode,
                              input logic [5:0] r_off, input logic [3:0] r_len,
                              input logic [5:0] g_off, input logic [3:0] g_len,
                              input logic [5:0] b_off, input logic [3:0] b_len,
                              input bit poke_unused);
    stop_sending();
    drain();
    write_reg(REG_MODE,    {5'($urandom), mode});
    write_reg(REG_RED_OFF, r_off);
    write_reg(REG_RED_LEN, {2'($urandom), r_len});
    write_reg(REG_GRN_OFF, g_off);
    write_reg(REG_GRN_LEN, {2'($urandom), g_len});
    write_reg(REG_BLU_OFF, b_off);
    write_reg(REG_BLU_LEN, {2'($urandom), b_len});
    if (poke_unused) write_reg(REG_NONE, 6'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic random_channel(output logic [5:0] off, output logic [3:0] len);
    case ($urandom_range(0, 9))
      0:       len = 4'd0;
      1:       len = 4'($urandom_range(9, 15));
      default: len = 4'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 9))
      0:       off = 6'($urandom_range(32, 63));
      1:       off = 6'($urandom_range(0, 31));
      default: off = (len <= 8) ? 6'($urandom_range(0, 32 - int'(len)))
                                : 6'($urandom_range(0, 31));
    endcase
  endtask

  task automatic test_rgb565_directed();
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_ffff);
    send_pixel(32'hffff_0000);  // upper half is ignored
    send_pixel(32'h0000_f800);
    send_pixel(32'h0000_07e0);
    send_pixel(32'h0000_001f);
    send_pixel(32'h0000_0821);
    send_pixel(32'ha5a5_5a5a);
    // Offsets and lengths have no effect in RGB565 mode
    apply_config(MODE_RGB565, 6'd63, 4'd15, 6'd40, 4'd0, 6'd33, 4'd9, 1'b0);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h1234_5678);
  endtask

  task automatic test_packed_directed();
    apply_config(MODE_PACKED, 6'd16, 4'd8, 6'd8, 4'd8, 6'd0, 4'd8, 1'b0);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0080_4020);
    // Zero-length and overlong channels, plus a write to an unused index
    apply_config(MODE_PACKED, 6'd0, 4'd0, 6'd0, 4'd9, 6'd0, 4'd15, 1'b1);
    send_pixel(32'hffff_ffff);
    // Offsets beyond the word, and a one-bit channel at the top bit
    apply_config(MODE_PACKED, 6'd32, 4'd1, 6'd63, 4'd8, 6'd31, 4'd1, 1'b0);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h8000_0000);
    // Field ending exactly at bit 31 versus one running past it
    apply_config(MODE_PACKED, 6'd24, 4'd8, 6'd25, 4'd8, 6'd0, 4'd1, 1'b0);
    send_pixel(32'hff00_0001);
    send_pixel(32'hffff_ffff);
    apply_config(MODE_PACKED, 6'd3, 4'd7, 6'd12, 4'd3, 6'd30, 4'd2, 1'b0);
    send_pixel($urandom);
    send_pixel($urandom);
  endtask

  task automatic test_rgb565_random();
    logic [5:0] off[3];
    logic [3:0] len[3];
    for (int c = 0; c < 3; c++) random_channel(off[c], len[c]);
    apply_config(MODE_RGB565, off[0], len[0], off[1], len[1], off[2], len[2],
                 1'b1);
    sender_burst = $urandom_range(0, 2) == 0;
    sink_burst   = $urandom_range(0, 2) == 0;
    repeat (100) send_pixel(random_pixel());
  endtask

  task automatic test_packed_random();
    logic [5:0] off[3];
    logic [3:0] len[3];
    for (int phase = 0; phase < 10; phase++) begin
      for (int c = 0; c < 3; c++) random_channel(off[c], len[c]);
      apply_config(MODE_PACKED, off[0], len[0], off[1], len[1], off[2], len[2],
                   $urandom_range(0, 3) == 0);
      sender_burst = $urandom_range(0, 3) == 0;
      sink_burst   = $urandom_range(0, 3) == 0;
      repeat (45) send_pixel(random_pixel());
    end
  endtask

  // Result sink: random back-pressure, compare each transaction in order
  initial begin
    rgb_t want;
    rgb_t got;
    int   stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait(sink_burst);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = rgb_t'(out_tdata);
      results_seen++;
      if (pending_rgb.size() == 0) begin
        $error("unexpected result 0x%06h", out_tdata);
        error_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (got.red !== want.red) begin
          $error("red_byte: expected %0d, got %0d", want.red, got.red);
          error_count++;
        end
        if (got.green !== want.green) begin
          $error("green_byte: expected %0d, got %0d", want.green, got.green);
          error_count++;
        end
        if (got.blue !== want.blue) begin
          $error("blue_byte: expected %0d, got %0d", want.blue, got.blue);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rgb565_directed();
    test_packed_directed();
    test_rgb565_random();
    test_packed_random();
    stop_sending();
    drain();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (pending_rgb.size() != 0) begin
      $error("%0d results never arrived", pending_rgb.size());
      error_count++;
    end
    $display("Expanded %0d RGB565 and %0d packed pixels, %0d results checked,",
             rgb565_pixels, packed_pixels, results_seen);
    $display("over %0d register settings with random gaps and back-pressure.",
             settings_used);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
